[src/saat_pkg.sv]
`timescale 1ns / 1ps

package saat_pkg;

    // Result status codes
    typedef logic [1:0] status_t;

    localparam status_t ST_REUSED = 2'd0;
    localparam status_t ST_NEW    = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    localparam int KEY_W     = 64;
    localparam int SHORT_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // One result word, status in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] device_count;
        logic [SHORT_W-1:0] node_addr;
        status_t            status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[src/saat_key_mem.sv]
`timescale 1ns / 1ps

module saat_key_mem #(
    parameter int SLOTS = 128,
    parameter int AW    = 7
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [saat_pkg::KEY_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [saat_pkg::KEY_W-1:0] rd_data
);
    import saat_pkg::*;

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [KEY_W-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/saat_scan_ctrl.sv]
`timescale 1ns / 1ps

module saat_scan_ctrl #(
    parameter int SLOTS = 128,
    parameter int AW    = 7,
    parameter int CW    = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [saat_pkg::KEY_W-1:0]  req_key,
    // key memory
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [saat_pkg::KEY_W-1:0]  mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [saat_pkg::KEY_W-1:0]  mem_rd_data,
    // result side
    input  logic                        res_free,
    output logic                        res_valid,
    output saat_pkg::result_t           res_word
);
    import saat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CW-1:0]      fill_reg, fill_next;      // slots 0..fill-1 are occupied
    logic [COUNT_W-1:0] count_reg, count_next;    // saturating device count
    logic [CW-1:0]      iss_reg, iss_next;        // next slot to read
    logic [AW-1:0]      chk_idx_reg, chk_idx_next; // slot whose key is on rd_data
    logic               chk_last_reg, chk_last_next;
    result_t            res_reg, res_next;

    logic               key_hit;
    logic [AW:0]        hit_short;
    logic [CW-1:0]      new_short;

    assign key_hit   = (mem_rd_data == key_reg);
    assign hit_short = {1'b0, chk_idx_reg} + (AW+1)'(1);
    assign new_short = fill_reg + CW'(1);

    // Next-state and datapath decisions
    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        chk_idx_next  = chk_idx_reg;
        chk_last_next = chk_last_reg;
        res_next      = res_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = fill_reg[AW-1:0];
        mem_wr_data   = key_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = iss_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    key_next = req_key;
                    if (fill_reg == CW'(0)) begin
                        state_next = S_DECIDE;
                    end else begin
                        // start the scan at slot zero
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = '0;
                        chk_idx_next  = '0;
                        chk_last_next = (fill_reg == CW'(1));
                        iss_next      = CW'(1);
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    res_next.status       = ST_REUSED;
                    res_next.node_addr    = SHORT_W'(hit_short);
                    res_next.device_count = count_reg;
                    state_next            = S_DONE;
                end else if (chk_last_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    // advance one slot per cycle
                    mem_rd_en     = 1'b1;
                    chk_idx_next  = iss_reg[AW-1:0];
                    chk_last_next = ((iss_reg + CW'(1)) == fill_reg);
                    iss_next      = iss_reg + CW'(1);
                end
            end
            S_DECIDE: begin
                if (fill_reg == CW'(SLOTS)) begin
                    res_next.status       = ST_FULL;
                    res_next.node_addr    = '0;
                    res_next.device_count = count_reg;
                end else begin
                    // claim the lowest free slot
                    mem_wr_en  = 1'b1;
                    fill_next  = new_short;
                    if (count_reg != {COUNT_W{1'b1}}) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    res_next.status       = ST_NEW;
                    res_next.node_addr    = SHORT_W'(new_short);
                    res_next.device_count = count_next;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        chk_last_reg <= chk_last_next;
        res_reg      <= res_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_word  = res_reg;

endmodule

[src/short_address_assign_table_unit.sv]
`timescale 1ns / 1ps

// Short address assignment table. Each 64-bit extended address word on the
// s_ channel gets one result word on the m_ channel: the short address of the
// slot that already holds it (status reused), or of the lowest free slot that
// it now claims (status new), or status full with short address 0. Keys sit in
// a single-port-read memory that is scanned one slot per cycle, and only
// occupied slots are read. Slots are never freed; no clearing pass is needed
// after reset. A finished result waits in an output register, so the next
// request is taken while the previous word is pending.
module short_address_assign_table_unit #(
    parameter int SLOTS = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [saat_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] ext_addr
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [saat_pkg::M_TDATA_W-1:0]  m_tdata    // [1:0] status,
                                                       // [9:2] node_addr,
                                                       // [17:10] device_count
);
    import saat_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [KEY_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [KEY_W-1:0] mem_rd_data;

    logic             res_valid;
    logic             res_free;
    result_t          res_word;

    logic             m_tvalid_reg;
    result_t          out_reg;

    saat_scan_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_key     (s_tdata),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res_word    (res_word)
    );

    saat_key_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: load a result when empty or being drained
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            out_reg <= res_word;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_reg};

endmodule

[src/saat_checker.sv]
`timescale 1ns / 1ps

module saat_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [saat_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [saat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import saat_pkg::*;

    logic [1:0] st;
    logic [7:0] sa;
    logic [7:0] dc;

    assign st = m_tdata[1:0];
    assign sa = m_tdata[9:2];
    assign dc = m_tdata[17:10];

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Status is one of the three codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == ST_REUSED || st == ST_NEW || st == ST_FULL))
        else $error("undefined status code");

    // Full status reports short address zero
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL) |-> (sa == 8'd0))
        else $error("full status with nonzero short address");

    // A new assignment leaves at least one device in the table, and the padding bits stay zero
    a_new_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_NEW) |-> (dc != 8'd0) && (m_tdata[23:18] == 6'd0))
        else $error("new assignment with zero device count or dirty padding");

    // A reuse can only follow a prior assignment
    a_reuse_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_REUSED) |-> (dc != 8'd0))
        else $error("reused entry reported with empty table");

endmodule

bind short_address_assign_table_unit saat_checker u_saat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/short_address_assign_table_unit_tb.sv]
`timescale 1ns / 1ps

module short_address_assign_table_unit_tb;

    import saat_pkg::*;

    localparam int SLOTS            = 128;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 2 * (SLOTS + 3);
    localparam int CYCLE_LIMIT      = 600_000;

    // Slot table mirror; answers each request the way the block should
    class slot_tracker;
        bit                 slot_taken[SLOTS];
        logic [KEY_W-1:0]   slot_ext_addr[SLOTS];
        int unsigned        devices;
        result_t            pending_assignments[$];
        int                 errors;

        function new();
            devices = 0;
            errors  = 0;
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        endfunction

        // Look up the address, else claim the lowest free slot, and queue the answer
        function void note_request(logic [KEY_W-1:0] ext_addr);
            result_t answer;
            int      hit;
            int      free_slot;
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (hit < 0 && slot_taken[i] && slot_ext_addr[i] == ext_addr) hit = i;
                if (free_slot < 0 && !slot_taken[i]) free_slot = i;
            end
            answer.status    = ST_FULL;
            answer.node_addr = '0;
            if (hit >= 0) begin
                answer.status    = ST_REUSED;
                answer.node_addr = SHORT_W'(hit + 1);
            end else if (free_slot >= 0) begin
                slot_taken[free_slot]    = 1'b1;
                slot_ext_addr[free_slot] = ext_addr;
                if (devices < 255) devices++;
                answer.status    = ST_NEW;
                answer.node_addr = SHORT_W'(free_slot + 1);
            end
            answer.device_count = COUNT_W'(devices);
            pending_assignments.push_back(answer);
        endfunction

        // Compare one result word against the oldest queued answer
        function void check_result(result_t got);
            result_t want;
            if (pending_assignments.size() == 0) begin
                $display("%0t: result word %h arrived with no request pending",
                         $time, got);
                errors++;
            end else begin
                want = pending_assignments.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.node_addr !== want.node_addr) begin
                    $display("%0t: node_addr expected %0d, got %0d",
                             $time, want.node_addr, got.node_addr);
                    errors++;
                end
                if (got.device_count !== want.device_count) begin
                    $display("%0t: device_count expected %0d, got %0d",
                             $time, want.device_count, got.device_count);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    slot_tracker            tracker;
    logic [KEY_W-1:0]       offered_addrs[$];
    int                     src_idle_pct  = 0;
    int                     sink_idle_pct = 0;
    int                     holds_asked   = 0;
    int                     holds_served  = 0;
    int                     hold_left     = 0;
    int unsigned            cycle_count   = 0;

    short_address_assign_table_unit #(
        .SLOTS(SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side ready: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = SINK_HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Watch both channels for accepted words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_result(result_t'(m_tdata[RESULT_W-1:0]));
            if (s_tvalid && s_tready) tracker.note_request(s_tdata);
        end
    end

    // Offer one address word, with random idle cycles ahead of it
    task automatic offer_ext_addr(input logic [KEY_W-1:0] ext_addr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ext_addr;
        offered_addrs.push_back(ext_addr);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly repeats and near misses of known addresses, the rest fresh ones
    task automatic run_random_requests(input int count);
        logic [KEY_W-1:0] ext_addr;
        int               pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                ext_addr = offered_addrs[$urandom_range(0, offered_addrs.size() - 1)];
            end else if (pick < 55) begin
                ext_addr = offered_addrs[$urandom_range(0, offered_addrs.size() - 1)]
                           ^ (64'd1 << $urandom_range(0, 63));
            end else begin
                ext_addr = {$urandom, $urandom};
            end
            offer_ext_addr(ext_addr);
        end
    endtask

    initial begin
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme addresses, first claims, repeats and one-bit neighbors
        src_idle_pct  = 22;
        sink_idle_pct = 75;
        offer_ext_addr(64'h0000_0000_0000_0000);
        offer_ext_addr(64'hFFFF_FFFF_FFFF_FFFF);
        offer_ext_addr(64'h0000_0000_0000_0000);
        offer_ext_addr(64'hFFFF_FFFF_FFFF_FFFF);
        offer_ext_addr(64'h8000_0000_0000_0000);
        offer_ext_addr(64'h0000_0000_0000_0001);
        offer_ext_addr(64'hAAAA_AAAA_AAAA_AAAA);
        offer_ext_addr(64'h5555_5555_5555_5555);
        offer_ext_addr(64'h5555_5555_5555_5555);
        offer_ext_addr(64'h8000_0000_0000_0000);
        offer_ext_addr(64'h0000_0001_0000_0000);
        offer_ext_addr(64'hFFFF_FFFF_FFFF_FFFE);
        offer_ext_addr(64'h0000_0000_0000_0001);
        offer_ext_addr(64'h0000_0001_0000_0000);

        // Random: sender light idling, receiver heavy, with one long hold-off
        run_random_requests(RANDOM_PER_PHASE / 2);
        holds_asked++;
        run_random_requests(RANDOM_PER_PHASE / 2);

        // Swap idling rates; the table fills here and full answers start
        src_idle_pct  = 75;
        sink_idle_pct = 22;
        run_random_requests(RANDOM_PER_PHASE);

        // No idling, and hold the receiver off while words keep coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        holds_asked++;
        run_random_requests(RANDOM_PER_PHASE);
        s_tvalid <= 1'b0;

        // Drain outstanding answers, then watch for strays
        while (tracker.pending_assignments.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending_assignments.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
src/saat_pkg.sv
src/saat_key_mem.sv
src/saat_scan_ctrl.sv
src/short_address_assign_table_unit.sv
src/saat_checker.sv
verif/short_address_assign_table_unit_tb.sv
